// ===== src/mrc_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the read-response checker.
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int FRAME_LEN     = 7;
  localparam int CHECKED_BYTES = 5;
  localparam int WINDOW_BYTES  = 14;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  BYTE_COUNT = 8'h02;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  ADDR_RESET    = 8'h01;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC      = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAVE_ADDRESS = 1'd0,
    REG_TIMEOUT_LIMIT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] value;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== src/mrc_crc16.sv =====
// Modbus CRC-16 over the header and register bytes of the window.
`timescale 1ns / 1ps

module mrc_crc16
  import mrc_pkg::*;
(
  input  logic [CHECKED_BYTES-1:0][7:0] data,
  output logic [15:0]                   crc
);

  always_comb begin
    crc = CRC_INIT;
    for (int k = 0; k < CHECKED_BYTES; k++) begin
      crc = crc16_byte(crc, data[k]);
    end
  end

endmodule

// ===== src/mrc_engine.sv =====
// Transaction state, byte window, header match and result decision.
`timescale 1ns / 1ps

module mrc_engine
  import mrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res,
  output logic    busy
);

  logic [7:0]  slave_addr_r;
  logic [15:0] timeout_limit_r;

  logic [FRAME_LEN-1:0][7:0] win_r, win_nxt, win_shift;
  logic [3:0]                seen_r, seen_nxt, seen_inc;
  logic                      busy_r, busy_nxt;
  logic [15:0]               tick_r, tick_nxt;
  logic [15:0]               crc;
  logic                      header_hit;
  logic                      tick_expired;

  assign win_shift = {item.rx_byte, win_r[FRAME_LEN-1:1]};
  assign seen_inc  = seen_r + 4'd1;

  mrc_crc16 u_crc (
    .data (win_shift[CHECKED_BYTES-1:0]),
    .crc  (crc)
  );

  assign header_hit = (seen_inc >= 4'(FRAME_LEN)) &&
                      (win_shift[0] == slave_addr_r) &&
                      (win_shift[1] == FUNC_READ) &&
                      (win_shift[2] == BYTE_COUNT);

  assign tick_expired = ({1'b0, tick_r} + 17'd1) >= {1'b0, timeout_limit_r};

  always_comb begin
    win_nxt   = win_r;
    seen_nxt  = seen_r;
    busy_nxt  = busy_r;
    tick_nxt  = tick_r;
    res.valid  = 1'b0;
    res.status = ST_OK;
    res.value  = 16'h0000;
    if (fire) begin
      case (item.action)
        ACT_START: begin
          win_nxt  = '0;
          seen_nxt = 4'd0;
          tick_nxt = 16'd0;
          busy_nxt = 1'b1;
        end
        ACT_BYTE: begin
          if (busy_r) begin
            win_nxt  = win_shift;
            seen_nxt = seen_inc;
            if (header_hit) begin
              res.valid = 1'b1;
              busy_nxt  = 1'b0;
              if (crc[7:0] == win_shift[5] && crc[15:8] == win_shift[6]) begin
                res.status = ST_OK;
                res.value  = {win_shift[3], win_shift[4]};
              end else begin
                res.status = ST_CRC;
              end
            end else if (seen_inc >= 4'(WINDOW_BYTES)) begin
              res.valid  = 1'b1;
              res.status = ST_OVERFLOW;
              busy_nxt   = 1'b0;
            end
          end
        end
        ACT_TICK: begin
          if (busy_r) begin
            if (tick_expired) begin
              res.valid  = 1'b1;
              res.status = ST_TIMEOUT;
              busy_nxt   = 1'b0;
            end else begin
              tick_nxt = tick_r + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r    <= ADDR_RESET;
      timeout_limit_r <= TIMEOUT_RESET;
      win_r           <= '0;
      seen_r          <= 4'd0;
      busy_r          <= 1'b0;
      tick_r          <= 16'd0;
    end else begin
      if (cfg.we && cfg.index == REG_SLAVE_ADDRESS) begin
        slave_addr_r <= cfg.data[7:0];
      end
      if (cfg.we && cfg.index == REG_TIMEOUT_LIMIT) begin
        timeout_limit_r <= cfg.data[15:0];
      end
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      busy_r <= busy_nxt;
      tick_r <= tick_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/modbus_read_response_checker.sv =====
// Top level of the Modbus read-response checker: input stage, engine and result register.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one item per handshake: in_tuser holds the action
// (start, received byte, time tick) and in_tdata the received byte. A start
// opens a transaction; bytes then slide through a seven-byte window until a
// read response for the configured slave address appears, whose CRC-16 is
// checked. The result stream delivers at most one item per input item:
// out_tuser holds the status and out_tdata the register value.
// An accepted item is registered in the input stage and processed by the engine
// once the result register can take it; its result, if any, is then registered.
// Throughput is one item per clock while the receiver does not stall; the five-byte
// CRC is evaluated combinationally while the item is processed.
// When the receiver stalls, one further item can be taken into the input
// register; after that in_tready drops until the result is taken.
// Reset clears the window, the counters and the handshake registers and
// loads slave address 1 and a timeout of 10000 ticks. Configuration writes
// take effect at the next clock edge and are meant for idle periods.

module modbus_read_response_checker
  import mrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic [1:0]            in_tuser,   // [1:0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] reg_value
  output logic [1:0]            out_tuser   // [1:0] status
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        advance;
  logic        out_valid_r;
  result_t     res;
  logic [15:0] out_value_r;
  status_t     out_status_r;
  logic        eng_busy;
  cfg_wr_t     cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.action  <= in_tuser;
      s1_item_r.rx_byte <= in_tdata;
    end
  end

  mrc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (advance),
    .item  (s1_item_r),
    .res   (res),
    .busy  (eng_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 16'h0000)
    else $error("register value is nonzero on a failing status");

  a_result_ends_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> !eng_busy)
    else $error("engine still busy after producing a result");

  a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled input stage lost or changed its item");

  a_result_loaded_when_produced: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> out_tvalid && out_tuser == $past(res.status))
    else $error("produced result not presented on the output");

endmodule
